>>> rtl/jes_pkg.sv
// ----------------------------------------------------------------------------
// jes_pkg
// Shared types, constants and helper functions of the Jacobi eigenvalue solver.
// ----------------------------------------------------------------------------
package jes_pkg;

    localparam int MAX_ORDER  = 16;
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int DATA_W     = 32;
    localparam int OP_W       = 34;
    localparam int ACC_W      = 36;

    // register indexes of the configuration port
    localparam logic [1:0] REG_MATRIX_SIZE     = 2'd0;
    localparam logic [1:0] REG_TOLERANCE_RATIO = 2'd1;
    localparam logic [1:0] REG_ROTATION_LIMIT  = 2'd2;

    // reset values of the configuration registers
    localparam logic [4:0]  SIZE_RESET  = 5'd4;
    localparam logic [31:0] RATIO_RESET = 32'd42950;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    // Q2.30 constants
    localparam logic signed [31:0] Q30_ONE        = 32'sd1073741824;
    localparam logic signed [31:0] HALF_SQRT2_Q30 = 32'sd759250125;

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_NORM_RD,
        ST_NORM_MUL,
        ST_NORM_ACC,
        ST_NORM_DONE,
        ST_SQRT,
        ST_DIV,
        ST_TOL_MUL,
        ST_TOL_SET,
        ST_CHECK,
        ST_PIV_INIT_RD,
        ST_PIV_INIT,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_ROT_RD_JJ,
        ST_ROT_RD_KK,
        ST_ROT_RD_JK,
        ST_ROT_CAP_JK,
        ST_ANGLE,
        ST_ANG_DD,
        ST_ANG_EE,
        ST_ANG_H,
        ST_ANG_T,
        ST_ANG_TT,
        ST_ANG_Q,
        ST_ANG_R,
        ST_ANG_C,
        ST_ANG_S,
        ST_ANG_SGN,
        ST_CC,
        ST_SS,
        ST_SC,
        ST_D1,
        ST_D2,
        ST_D3,
        ST_D4,
        ST_D5,
        ST_WJJ,
        ST_WKK,
        ST_WJK,
        ST_WKJ,
        ST_IL,
        ST_IR1,
        ST_IR2,
        ST_IR3,
        ST_IR4,
        ST_IR5,
        ST_IW2,
        ST_IW3,
        ST_IW4,
        ST_ROT_DONE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    // magnitude of a signed operand
    function automatic logic [31:0] mag(input logic signed [OP_W-1:0] v);
        logic [OP_W-1:0] a;
        begin
            a = v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
            mag = a[31:0];
        end
    endfunction

    // saturate to the element width
    function automatic logic signed [DATA_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        begin
            hi = ACC_W'(32'sh7FFFFFFF);
            lo = -hi - ACC_W'(1);
            if (v > hi)
                sat = 32'sh7FFFFFFF;
            else if (v < lo)
                sat = 32'sh80000000;
            else
                sat = v[DATA_W-1:0];
        end
    endfunction

endpackage

>>> rtl/jacobi_eigenvalue_solver.sv
// ----------------------------------------------------------------------------
// jacobi_eigenvalue_solver
// Classical Jacobi eigenvalue solver with largest-pivot rotations in fixed
// point, built on one shared multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
// Elements are loaded one per cycle in row-major order with start while busy
// is low. The request that brings the last element starts the solve and busy
// stays high until the last eigenvalue has been sent. Eigenvalues come out one
// at a time after a diagonal read, each on result_strobe for a single cycle; the
// receiver must take them as they come. Each off-diagonal norm pass sends every
// element through the shared multiplier and then runs a 32-step square root;
// each pivot search scans the whole matrix; each rotation computes the angle
// (two 32-step square roots and two 31-step divisions unless it is trivial)
// and then updates every row outside the pivot pair. The matrix store is a
// 256-entry memory with one read and one write a cycle.
module jacobi_eigenvalue_solver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  element_value,
    input  logic                write_enable,
    input  logic [1:0]          write_index,
    input  logic [31:0]         write_data,
    output logic                result_strobe,
    output logic signed [31:0]  eigen_value,
    output logic [3:0]          eigen_index,
    output logic                last_flag,
    output logic                converged_flag
);

    jes_pkg::state_t state_reg, state_next;
    jes_pkg::state_t sq_ret_reg, dv_ret_reg;

    // configuration
    logic [4:0]  size_reg;
    logic [31:0] ratio_reg;
    logic [15:0] limit_reg;
    logic [jes_pkg::IDX_W-1:0] nm1;

    // matrix store
    logic signed [31:0] mem [0:(1 << jes_pkg::ADDR_W)-1];
    logic signed [31:0] rd_data_reg;
    logic [jes_pkg::ADDR_W-1:0] rd_addr, wr_addr;
    logic        wr_en;
    logic signed [31:0] wr_data;

    // counters and control
    logic [jes_pkg::IDX_W-1:0] ld_row_reg, ld_col_reg;
    logic [jes_pkg::IDX_W-1:0] cnt_a_reg, cnt_b_reg;
    logic [jes_pkg::IDX_W-1:0] pj_reg, pk_reg;
    logic [15:0] rot_cnt_reg;
    logic        first_reg, conv_reg, sgn_reg;

    // norm
    logic [63:0] sum_reg, sum_add;
    logic [31:0] norm_reg, tol_reg, best_reg;

    // shared multiplier
    logic signed [jes_pkg::OP_W-1:0] mul_a, mul_b;
    logic [63:0] prod_reg, prod_rnd;
    logic        neg_reg;
    logic signed [jes_pkg::ACC_W-1:0] mq;

    // square root unit
    logic [63:0] sq_x_reg, sq_r_reg, sq_bit, sq_trial;
    logic [4:0]  sq_step_reg;

    // divider
    logic [33:0] dv_rem_reg, dv_div_reg;
    logic [34:0] dv_trial;
    logic [30:0] dv_low_reg, dv_quo_reg;
    logic [4:0]  dv_cnt_reg;

    // rotation
    logic signed [31:0] ajj_reg, akk_reg, ajk_reg, rj_reg, rk_reg, nj_reg, nk_reg;
    logic signed [31:0] c_reg, s_reg;
    logic signed [jes_pkg::ACC_W-1:0] cc_reg, ss_reg, sc_reg;
    logic signed [jes_pkg::ACC_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, x1_reg;
    logic [30:0] ud_reg, ue_reg, tn_reg;

    // angle preparation
    logic signed [32:0] ang_d, ang_e;
    logic [32:0] ang_ud, ang_ue, ang_ud_s, ang_ue_s;
    logic signed [jes_pkg::ACC_W-1:0] dg_jj, dg_kk;
    logic [30:0] cu_clamped;
    logic [31:0] q_val;

    // order in use
    always_comb
    begin
        if (size_reg < 5'd2)
            nm1 = jes_pkg::IDX_W'(1);
        else if (size_reg > 5'(jes_pkg::MAX_ORDER))
            nm1 = jes_pkg::IDX_W'(jes_pkg::MAX_ORDER - 1);
        else
            nm1 = jes_pkg::IDX_W'(size_reg - 5'd1);
    end

    // rounded signed product of the shared multiplier
    always_comb
    begin
        prod_rnd = prod_reg + (64'd1 << 29);
        mq = neg_reg ? -$signed({2'b00, prod_rnd[63:30]})
                     :  $signed({2'b00, prod_rnd[63:30]});
    end

    // square root and divider steps
    always_comb
    begin
        sq_bit   = 64'd1 << (6'd62 - {sq_step_reg, 1'b0});
        sq_trial = sq_r_reg + sq_bit;
        dv_trial = {dv_rem_reg, dv_low_reg[30]};
    end

    // angle operands
    always_comb
    begin
        ang_d  = {ajj_reg[31], ajj_reg} - {akk_reg[31], akk_reg};
        ang_e  = {ajk_reg, 1'b0};
        ang_ud = ang_d[32] ? 33'(-ang_d) : 33'(ang_d);
        ang_ue = ang_e[32] ? 33'(-ang_e) : 33'(ang_e);
        if (ang_ud[32] | ang_ue[32])
        begin
            ang_ud_s = ang_ud >> 2;
            ang_ue_s = ang_ue >> 2;
        end
        else if (ang_ud[31] | ang_ue[31])
        begin
            ang_ud_s = ang_ud >> 1;
            ang_ue_s = ang_ue >> 1;
        end
        else
        begin
            ang_ud_s = ang_ud;
            ang_ue_s = ang_ue;
        end
        cu_clamped = (dv_quo_reg > 31'(jes_pkg::Q30_ONE)) ? 31'(jes_pkg::Q30_ONE) : dv_quo_reg;
        q_val  = 32'(jes_pkg::Q30_ONE) + mq[31:0];
        dg_jj  = t1_reg + (t2_reg <<< 1) + t3_reg;
        dg_kk  = t4_reg - (t2_reg <<< 1) + t5_reg;
        sum_add = (cnt_a_reg != cnt_b_reg) ? (prod_reg >> 16) : 64'd0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jes_pkg::ST_LOAD:
                if (start && (ld_col_reg == nm1) && (ld_row_reg == nm1))
                    state_next = jes_pkg::ST_NORM_RD;
            jes_pkg::ST_NORM_RD:     state_next = jes_pkg::ST_NORM_MUL;
            jes_pkg::ST_NORM_MUL:    state_next = jes_pkg::ST_NORM_ACC;
            jes_pkg::ST_NORM_ACC:
                if ((cnt_b_reg == nm1) && (cnt_a_reg == nm1))
                    state_next = jes_pkg::ST_SQRT;
                else
                    state_next = jes_pkg::ST_NORM_RD;
            jes_pkg::ST_NORM_DONE:
                state_next = first_reg ? jes_pkg::ST_TOL_MUL : jes_pkg::ST_CHECK;
            jes_pkg::ST_SQRT:
                if (sq_step_reg == 5'd31)
                    state_next = sq_ret_reg;
            jes_pkg::ST_DIV:
                if (dv_cnt_reg == 5'd30)
                    state_next = dv_ret_reg;
            jes_pkg::ST_TOL_MUL:     state_next = jes_pkg::ST_TOL_SET;
            jes_pkg::ST_TOL_SET:     state_next = jes_pkg::ST_CHECK;
            jes_pkg::ST_CHECK:
                if ((norm_reg > tol_reg) && (rot_cnt_reg < limit_reg))
                    state_next = jes_pkg::ST_PIV_INIT_RD;
                else
                    state_next = jes_pkg::ST_EMIT_RD;
            jes_pkg::ST_PIV_INIT_RD: state_next = jes_pkg::ST_PIV_INIT;
            jes_pkg::ST_PIV_INIT:    state_next = jes_pkg::ST_PIV_RD;
            jes_pkg::ST_PIV_RD:      state_next = jes_pkg::ST_PIV_CMP;
            jes_pkg::ST_PIV_CMP:
                if ((cnt_a_reg == nm1) && (cnt_b_reg == nm1))
                    state_next = jes_pkg::ST_ROT_RD_JJ;
                else
                    state_next = jes_pkg::ST_PIV_RD;
            jes_pkg::ST_ROT_RD_JJ:   state_next = jes_pkg::ST_ROT_RD_KK;
            jes_pkg::ST_ROT_RD_KK:   state_next = jes_pkg::ST_ROT_RD_JK;
            jes_pkg::ST_ROT_RD_JK:   state_next = jes_pkg::ST_ROT_CAP_JK;
            jes_pkg::ST_ROT_CAP_JK:  state_next = jes_pkg::ST_ANGLE;
            jes_pkg::ST_ANGLE:
                if ((ajj_reg == akk_reg) || (ajk_reg == 32'sd0))
                    state_next = jes_pkg::ST_CC;
                else
                    state_next = jes_pkg::ST_ANG_DD;
            jes_pkg::ST_ANG_DD:      state_next = jes_pkg::ST_ANG_EE;
            jes_pkg::ST_ANG_EE:      state_next = jes_pkg::ST_ANG_H;
            jes_pkg::ST_ANG_H:       state_next = jes_pkg::ST_SQRT;
            jes_pkg::ST_ANG_T:       state_next = jes_pkg::ST_DIV;
            jes_pkg::ST_ANG_TT:      state_next = jes_pkg::ST_ANG_Q;
            jes_pkg::ST_ANG_Q:       state_next = jes_pkg::ST_SQRT;
            jes_pkg::ST_ANG_R:       state_next = jes_pkg::ST_DIV;
            jes_pkg::ST_ANG_C:       state_next = jes_pkg::ST_ANG_S;
            jes_pkg::ST_ANG_S:       state_next = jes_pkg::ST_ANG_SGN;
            jes_pkg::ST_ANG_SGN:     state_next = jes_pkg::ST_CC;
            jes_pkg::ST_CC:          state_next = jes_pkg::ST_SS;
            jes_pkg::ST_SS:          state_next = jes_pkg::ST_SC;
            jes_pkg::ST_SC:          state_next = jes_pkg::ST_D1;
            jes_pkg::ST_D1:          state_next = jes_pkg::ST_D2;
            jes_pkg::ST_D2:          state_next = jes_pkg::ST_D3;
            jes_pkg::ST_D3:          state_next = jes_pkg::ST_D4;
            jes_pkg::ST_D4:          state_next = jes_pkg::ST_D5;
            jes_pkg::ST_D5:          state_next = jes_pkg::ST_WJJ;
            jes_pkg::ST_WJJ:         state_next = jes_pkg::ST_WKK;
            jes_pkg::ST_WKK:         state_next = jes_pkg::ST_WJK;
            jes_pkg::ST_WJK:         state_next = jes_pkg::ST_WKJ;
            jes_pkg::ST_WKJ:         state_next = jes_pkg::ST_IL;
            jes_pkg::ST_IL:
                if ((cnt_a_reg == pj_reg) || (cnt_a_reg == pk_reg))
                begin
                    if (cnt_a_reg == nm1)
                        state_next = jes_pkg::ST_ROT_DONE;
                end
                else
                    state_next = jes_pkg::ST_IR1;
            jes_pkg::ST_IR1:         state_next = jes_pkg::ST_IR2;
            jes_pkg::ST_IR2:         state_next = jes_pkg::ST_IR3;
            jes_pkg::ST_IR3:         state_next = jes_pkg::ST_IR4;
            jes_pkg::ST_IR4:         state_next = jes_pkg::ST_IR5;
            jes_pkg::ST_IR5:         state_next = jes_pkg::ST_IW2;
            jes_pkg::ST_IW2:         state_next = jes_pkg::ST_IW3;
            jes_pkg::ST_IW3:         state_next = jes_pkg::ST_IW4;
            jes_pkg::ST_IW4:
                state_next = (cnt_a_reg == nm1) ? jes_pkg::ST_ROT_DONE : jes_pkg::ST_IL;
            jes_pkg::ST_ROT_DONE:    state_next = jes_pkg::ST_NORM_RD;
            jes_pkg::ST_EMIT_RD:     state_next = jes_pkg::ST_EMIT_OUT;
            jes_pkg::ST_EMIT_OUT:
                state_next = (cnt_a_reg == nm1) ? jes_pkg::ST_LOAD : jes_pkg::ST_EMIT_RD;
            default:                 state_next = jes_pkg::ST_LOAD;
        endcase
    end

    // memory ports, multiplier operands and result outputs
    always_comb
    begin
        rd_addr = {cnt_a_reg, cnt_b_reg};
        wr_en   = 1'b0;
        wr_addr = {ld_row_reg, ld_col_reg};
        wr_data = element_value;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            jes_pkg::ST_LOAD:
                wr_en = start;
            jes_pkg::ST_NORM_MUL:
            begin
                mul_a = jes_pkg::OP_W'(rd_data_reg);
                mul_b = jes_pkg::OP_W'(rd_data_reg);
            end
            jes_pkg::ST_TOL_MUL:
            begin
                mul_a = $signed({2'b00, norm_reg});
                mul_b = $signed({2'b00, ratio_reg});
            end
            jes_pkg::ST_PIV_INIT_RD:
                rd_addr = {jes_pkg::IDX_W'(1), jes_pkg::IDX_W'(0)};
            jes_pkg::ST_ROT_RD_JJ:
                rd_addr = {pj_reg, pj_reg};
            jes_pkg::ST_ROT_RD_KK:
                rd_addr = {pk_reg, pk_reg};
            jes_pkg::ST_ROT_RD_JK:
                rd_addr = {pj_reg, pk_reg};
            jes_pkg::ST_ANG_DD:
            begin
                mul_a = $signed({3'b000, ud_reg});
                mul_b = $signed({3'b000, ud_reg});
            end
            jes_pkg::ST_ANG_EE:
            begin
                mul_a = $signed({3'b000, ue_reg});
                mul_b = $signed({3'b000, ue_reg});
            end
            jes_pkg::ST_ANG_TT:
            begin
                mul_a = $signed({3'b000, dv_quo_reg});
                mul_b = $signed({3'b000, dv_quo_reg});
            end
            jes_pkg::ST_ANG_S:
            begin
                mul_a = jes_pkg::OP_W'(c_reg);
                mul_b = $signed({3'b000, tn_reg});
            end
            jes_pkg::ST_CC:
            begin
                mul_a = jes_pkg::OP_W'(c_reg);
                mul_b = jes_pkg::OP_W'(c_reg);
            end
            jes_pkg::ST_SS:
            begin
                mul_a = jes_pkg::OP_W'(s_reg);
                mul_b = jes_pkg::OP_W'(s_reg);
            end
            jes_pkg::ST_SC:
            begin
                mul_a = jes_pkg::OP_W'(s_reg);
                mul_b = jes_pkg::OP_W'(c_reg);
            end
            jes_pkg::ST_D1:
            begin
                mul_a = jes_pkg::OP_W'(ajj_reg);
                mul_b = cc_reg[jes_pkg::OP_W-1:0];
            end
            jes_pkg::ST_D2:
            begin
                mul_a = jes_pkg::OP_W'(ajk_reg);
                mul_b = sc_reg[jes_pkg::OP_W-1:0];
            end
            jes_pkg::ST_D3:
            begin
                mul_a = jes_pkg::OP_W'(akk_reg);
                mul_b = ss_reg[jes_pkg::OP_W-1:0];
            end
            jes_pkg::ST_D4:
            begin
                mul_a = jes_pkg::OP_W'(ajj_reg);
                mul_b = ss_reg[jes_pkg::OP_W-1:0];
            end
            jes_pkg::ST_D5:
            begin
                mul_a = jes_pkg::OP_W'(akk_reg);
                mul_b = cc_reg[jes_pkg::OP_W-1:0];
            end
            jes_pkg::ST_WJJ:
            begin
                wr_en   = 1'b1;
                wr_addr = {pj_reg, pj_reg};
                wr_data = jes_pkg::sat(dg_jj);
            end
            jes_pkg::ST_WKK:
            begin
                wr_en   = 1'b1;
                wr_addr = {pk_reg, pk_reg};
                wr_data = jes_pkg::sat(dg_kk);
            end
            jes_pkg::ST_WJK:
            begin
                wr_en   = 1'b1;
                wr_addr = {pj_reg, pk_reg};
                wr_data = 32'sd0;
            end
            jes_pkg::ST_WKJ:
            begin
                wr_en   = 1'b1;
                wr_addr = {pk_reg, pj_reg};
                wr_data = 32'sd0;
            end
            jes_pkg::ST_IL:
                rd_addr = {pj_reg, cnt_a_reg};
            jes_pkg::ST_IR1:
            begin
                rd_addr = {pk_reg, cnt_a_reg};
                mul_a   = jes_pkg::OP_W'(rd_data_reg);
                mul_b   = jes_pkg::OP_W'(c_reg);
            end
            jes_pkg::ST_IR2:
            begin
                mul_a = jes_pkg::OP_W'(rd_data_reg);
                mul_b = jes_pkg::OP_W'(s_reg);
            end
            jes_pkg::ST_IR3:
            begin
                mul_a = jes_pkg::OP_W'(rj_reg);
                mul_b = jes_pkg::OP_W'(s_reg);
            end
            jes_pkg::ST_IR4:
            begin
                mul_a = jes_pkg::OP_W'(rk_reg);
                mul_b = jes_pkg::OP_W'(c_reg);
            end
            jes_pkg::ST_IR5:
            begin
                wr_en   = 1'b1;
                wr_addr = {pj_reg, cnt_a_reg};
                wr_data = nj_reg;
            end
            jes_pkg::ST_IW2:
            begin
                wr_en   = 1'b1;
                wr_addr = {cnt_a_reg, pj_reg};
                wr_data = nj_reg;
            end
            jes_pkg::ST_IW3:
            begin
                wr_en   = 1'b1;
                wr_addr = {pk_reg, cnt_a_reg};
                wr_data = nk_reg;
            end
            jes_pkg::ST_IW4:
            begin
                wr_en   = 1'b1;
                wr_addr = {cnt_a_reg, pk_reg};
                wr_data = nk_reg;
            end
            jes_pkg::ST_EMIT_RD:
                rd_addr = {cnt_a_reg, cnt_a_reg};
            default:
            begin
                rd_addr = {cnt_a_reg, cnt_b_reg};
            end
        endcase
    end

    // handshake and result ports
    assign busy           = (state_reg != jes_pkg::ST_LOAD);
    assign result_strobe  = (state_reg == jes_pkg::ST_EMIT_OUT);
    assign eigen_value    = rd_data_reg;
    assign eigen_index    = cnt_a_reg;
    assign last_flag      = (cnt_a_reg == nm1);
    assign converged_flag = conv_reg;

    // matrix store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // shared multiplier, magnitude product with registered sign
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(jes_pkg::mag(mul_a)) * 64'(jes_pkg::mag(mul_b));
        neg_reg  <= mul_a[jes_pkg::OP_W-1] ^ mul_b[jes_pkg::OP_W-1];
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jes_pkg::ST_LOAD;
            size_reg  <= jes_pkg::SIZE_RESET;
            ratio_reg <= jes_pkg::RATIO_RESET;
            limit_reg <= jes_pkg::LIMIT_RESET;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && (state_reg == jes_pkg::ST_LOAD))
            begin
                if (ld_col_reg == nm1)
                begin
                    ld_col_reg <= '0;
                    ld_row_reg <= (ld_row_reg == nm1) ? '0 : ld_row_reg + 1'b1;
                end
                else
                    ld_col_reg <= ld_col_reg + 1'b1;
            end
            if (write_enable)
            begin
                unique case (write_index)
                    jes_pkg::REG_MATRIX_SIZE:
                    begin
                        size_reg   <= write_data[4:0];
                        ld_row_reg <= '0;
                        ld_col_reg <= '0;
                    end
                    jes_pkg::REG_TOLERANCE_RATIO:
                        ratio_reg <= write_data;
                    jes_pkg::REG_ROTATION_LIMIT:
                        limit_reg <= write_data[15:0];
                    default:
                    begin
                        size_reg <= size_reg;
                    end
                endcase
            end
        end
    end

    // sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            rot_cnt_reg <= '0;
            first_reg   <= 1'b0;
            conv_reg    <= 1'b0;
            sq_step_reg <= '0;
            dv_cnt_reg  <= '0;
            sq_ret_reg  <= jes_pkg::ST_NORM_DONE;
            dv_ret_reg  <= jes_pkg::ST_ANG_TT;
        end
        else
        begin
            case (state_reg)
                jes_pkg::ST_LOAD:
                    if (start && (ld_col_reg == nm1) && (ld_row_reg == nm1))
                    begin
                        cnt_a_reg   <= '0;
                        cnt_b_reg   <= '0;
                        rot_cnt_reg <= '0;
                        first_reg   <= 1'b1;
                    end
                jes_pkg::ST_NORM_ACC:
                    if (cnt_b_reg == nm1)
                    begin
                        cnt_b_reg <= '0;
                        if (cnt_a_reg == nm1)
                        begin
                            cnt_a_reg   <= '0;
                            sq_step_reg <= '0;
                            sq_ret_reg  <= jes_pkg::ST_NORM_DONE;
                        end
                        else
                            cnt_a_reg <= cnt_a_reg + 1'b1;
                    end
                    else
                        cnt_b_reg <= cnt_b_reg + 1'b1;
                jes_pkg::ST_SQRT:
                    sq_step_reg <= sq_step_reg + 1'b1;
                jes_pkg::ST_DIV:
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                jes_pkg::ST_TOL_SET:
                    first_reg <= 1'b0;
                jes_pkg::ST_CHECK:
                begin
                    cnt_a_reg <= '0;
                    cnt_b_reg <= '0;
                    conv_reg  <= !(norm_reg > tol_reg);
                end
                jes_pkg::ST_PIV_CMP:
                    if (cnt_a_reg == nm1)
                    begin
                        cnt_a_reg <= '0;
                        cnt_b_reg <= (cnt_b_reg == nm1) ? '0 : cnt_b_reg + 1'b1;
                    end
                    else
                        cnt_a_reg <= cnt_a_reg + 1'b1;
                jes_pkg::ST_ANG_H:
                begin
                    sq_step_reg <= '0;
                    sq_ret_reg  <= jes_pkg::ST_ANG_T;
                end
                jes_pkg::ST_ANG_T:
                begin
                    dv_cnt_reg <= '0;
                    dv_ret_reg <= jes_pkg::ST_ANG_TT;
                end
                jes_pkg::ST_ANG_Q:
                begin
                    sq_step_reg <= '0;
                    sq_ret_reg  <= jes_pkg::ST_ANG_R;
                end
                jes_pkg::ST_ANG_R:
                begin
                    dv_cnt_reg <= '0;
                    dv_ret_reg <= jes_pkg::ST_ANG_C;
                end
                jes_pkg::ST_WKJ:
                    cnt_a_reg <= '0;
                jes_pkg::ST_IL:
                    if (((cnt_a_reg == pj_reg) || (cnt_a_reg == pk_reg)) && (cnt_a_reg != nm1))
                        cnt_a_reg <= cnt_a_reg + 1'b1;
                jes_pkg::ST_IW4:
                    if (cnt_a_reg != nm1)
                        cnt_a_reg <= cnt_a_reg + 1'b1;
                jes_pkg::ST_ROT_DONE:
                begin
                    rot_cnt_reg <= rot_cnt_reg + 1'b1;
                    cnt_a_reg   <= '0;
                    cnt_b_reg   <= '0;
                end
                jes_pkg::ST_EMIT_OUT:
                    cnt_a_reg <= (cnt_a_reg == nm1) ? '0 : cnt_a_reg + 1'b1;
                default:
                begin
                    cnt_a_reg <= cnt_a_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            jes_pkg::ST_LOAD:
                sum_reg <= '0;
            jes_pkg::ST_NORM_ACC:
            begin
                sum_reg  <= sum_reg + sum_add;
                sq_x_reg <= sum_reg + sum_add;
                sq_r_reg <= '0;
            end
            jes_pkg::ST_SQRT:
                if (sq_x_reg >= sq_trial)
                begin
                    sq_x_reg <= sq_x_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
            jes_pkg::ST_DIV:
            begin
                if (dv_trial >= {1'b0, dv_div_reg})
                begin
                    dv_rem_reg <= 34'(dv_trial - {1'b0, dv_div_reg});
                    dv_quo_reg <= {dv_quo_reg[29:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg <= dv_trial[33:0];
                    dv_quo_reg <= {dv_quo_reg[29:0], 1'b0};
                end
                dv_low_reg <= {dv_low_reg[29:0], 1'b0};
            end
            jes_pkg::ST_NORM_DONE:
                norm_reg <= sq_r_reg[31:0];
            jes_pkg::ST_TOL_SET:
                tol_reg <= prod_reg[63:32];
            jes_pkg::ST_PIV_INIT:
            begin
                best_reg <= jes_pkg::mag(jes_pkg::OP_W'(rd_data_reg));
                pj_reg   <= jes_pkg::IDX_W'(0);
                pk_reg   <= jes_pkg::IDX_W'(1);
            end
            jes_pkg::ST_PIV_CMP:
                if ((cnt_a_reg != cnt_b_reg) &&
                    (jes_pkg::mag(jes_pkg::OP_W'(rd_data_reg)) > best_reg))
                begin
                    best_reg <= jes_pkg::mag(jes_pkg::OP_W'(rd_data_reg));
                    pj_reg   <= cnt_a_reg;
                    pk_reg   <= cnt_b_reg;
                end
            jes_pkg::ST_ROT_RD_KK:
                ajj_reg <= rd_data_reg;
            jes_pkg::ST_ROT_RD_JK:
                akk_reg <= rd_data_reg;
            jes_pkg::ST_ROT_CAP_JK:
                ajk_reg <= rd_data_reg;
            jes_pkg::ST_ANGLE:
            begin
                ud_reg  <= ang_ud_s[30:0];
                ue_reg  <= ang_ue_s[30:0];
                sgn_reg <= ang_d[32] ^ ang_e[32];
                if (ajj_reg == akk_reg)
                begin
                    c_reg <= jes_pkg::HALF_SQRT2_Q30;
                    s_reg <= jes_pkg::HALF_SQRT2_Q30;
                end
                else
                begin
                    c_reg <= jes_pkg::Q30_ONE;
                    s_reg <= 32'sd0;
                end
            end
            jes_pkg::ST_ANG_EE:
                sum_reg <= prod_reg;
            jes_pkg::ST_ANG_H:
            begin
                sq_x_reg <= sum_reg + prod_reg;
                sq_r_reg <= '0;
            end
            jes_pkg::ST_ANG_T:
            begin
                // dividend is ue shifted up by 30
                dv_rem_reg <= {4'b0000, ue_reg[30:1]};
                dv_low_reg <= {ue_reg[0], 30'd0};
                dv_div_reg <= 34'(ud_reg) + 34'(sq_r_reg[31:0]);
                dv_quo_reg <= '0;
            end
            jes_pkg::ST_ANG_TT:
                tn_reg <= dv_quo_reg;
            jes_pkg::ST_ANG_Q:
            begin
                sq_x_reg <= {2'b00, q_val, 30'd0};
                sq_r_reg <= '0;
            end
            jes_pkg::ST_ANG_R:
            begin
                // dividend is 2^60 plus half the root
                dv_rem_reg <= 34'(((64'd1 << 60) + (sq_r_reg >> 1)) >> 31);
                dv_low_reg <= sq_r_reg[31:1];
                dv_div_reg <= sq_r_reg[33:0];
                dv_quo_reg <= '0;
            end
            jes_pkg::ST_ANG_C:
                c_reg <= $signed({1'b0, cu_clamped});
            jes_pkg::ST_ANG_SGN:
                s_reg <= sgn_reg ? -mq[31:0] : mq[31:0];
            jes_pkg::ST_SS:
                cc_reg <= mq;
            jes_pkg::ST_SC:
                ss_reg <= mq;
            jes_pkg::ST_D1:
                sc_reg <= mq;
            jes_pkg::ST_D2:
                t1_reg <= mq;
            jes_pkg::ST_D3:
                t2_reg <= mq;
            jes_pkg::ST_D4:
                t3_reg <= mq;
            jes_pkg::ST_D5:
                t4_reg <= mq;
            jes_pkg::ST_WJJ:
                t5_reg <= mq;
            jes_pkg::ST_IR1:
                rj_reg <= rd_data_reg;
            jes_pkg::ST_IR2:
            begin
                x1_reg <= mq;
                rk_reg <= rd_data_reg;
            end
            jes_pkg::ST_IR3:
                nj_reg <= jes_pkg::sat(x1_reg + mq);
            jes_pkg::ST_IR4:
                x1_reg <= mq;
            jes_pkg::ST_IR5:
                nk_reg <= jes_pkg::sat(x1_reg - mq);
            jes_pkg::ST_ROT_DONE:
                sum_reg <= '0;
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // results only come out of a solve
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    // the final eigenvalue hands the block back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_flag) |=> !busy)
        else $error("block still busy after final eigenvalue");

    // results are spaced by the diagonal read
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_flag) |=> !result_strobe)
        else $error("back to back result strobes");

    // the pivot pair never collapses to a diagonal entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jes_pkg::ST_WJK) |-> (pj_reg != pk_reg))
        else $error("pivot on the diagonal");

    // the angle divider always holds a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jes_pkg::ST_DIV) |-> (dv_div_reg != 34'd0))
        else $error("divider started with zero divisor");
`endif

endmodule
